// ===== hdl/tausworthe_lfsr_generator_macros.svh =====
// Assertion macros shared by the generator's controller and datapath.
// Defining ASSERT_OFF turns every check into an empty statement.
`ifndef TAUSWORTHE_LFSR_GENERATOR_MACROS_SVH
`define TAUSWORTHE_LFSR_GENERATOR_MACROS_SVH

`ifndef ASSERT_OFF
`define TLG_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define TLG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define TLG_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define TLG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== hdl/tlg_pkg.sv =====
// Shared constants, types and recurrence functions of the Tausworthe generator.
// Used by tlg_ctrl, tlg_dpath and the top level; depends on nothing.
`default_nettype none

package tlg_pkg;

  localparam int WORD_BITS       = 32;
  localparam int MAX_MIDDLE_TAPS = 3;
  localparam int ADV_PER_CYCLE   = 4;
  localparam int IDX_W           = $clog2(WORD_BITS);

  localparam int K_W        = 5;
  localparam int S_W        = 8;
  localparam int NT_W       = 2;
  localparam int TAP_W      = 5;
  localparam int P_W        = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;
  localparam int SEED_W     = 32;
  localparam int OUT_W      = 32;

  localparam logic [CFG_IDX_W-1:0] REG_DEGREE_K   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_S     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIDDLE_TAP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TAP_ONE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TAP_TWO    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TAP_THREE  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_QUICK_MODE = 3'd6;

  localparam logic CMD_SEED = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [MAX_MIDDLE_TAPS-1:0][TAP_W-1:0] taps_t;

  typedef struct packed {
    logic load;
    logic advance;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic rem_zero;
  } status_t;

  // Bit p of (x << 1), vector numbering; outside the word reads as zero.
  function automatic logic shifted_bit(word_t x, logic signed [P_W-1:0] p);
    logic [IDX_W-1:0] idx;
    logic             b;
    idx = IDX_W'(p - P_W'(1));
    if (p < P_W'(1) || p > P_W'(WORD_BITS - 1)) begin
      b = 1'b0;
    end else begin
      b = x[idx];
    end
    return b;
  endfunction

  // Shift one bit in and fill the new last bit from the recurrence.
  function automatic word_t advance_one(word_t x, logic [K_W-1:0] k, taps_t taps,
                                        logic [NT_W-1:0] n);
    logic                  nb;
    logic signed [P_W-1:0] p;
    nb = shifted_bit(x, P_W'({2'b00, k}));
    for (int i = 0; i < MAX_MIDDLE_TAPS; i++) begin
      p = P_W'({2'b00, k}) - P_W'({2'b00, taps[i]});
      if (i < int'(n)) begin
        nb = nb ^ shifted_bit(x, p);
      end
    end
    return {x[WORD_BITS-2:0], nb};
  endfunction

  // Word-parallel step: ((x & topk) << s) ^ ((x ^ x<<q...) >> max(k-s, 0)).
  function automatic word_t quick_word(word_t x, logic [K_W-1:0] k, logic [S_W-1:0] s,
                                       taps_t taps, logic [NT_W-1:0] n);
    word_t          b;
    word_t          topk;
    logic [S_W-1:0] rs;
    b    = x;
    topk = ~({WORD_BITS{1'b1}} >> k);
    for (int i = 0; i < MAX_MIDDLE_TAPS; i++) begin
      if (i < int'(n)) begin
        b = b ^ (x << taps[i]);
      end
    end
    rs = (S_W'(k) > s) ? (S_W'(k) - s) : '0;
    b  = b >> rs;
    return ((x & topk) << s) ^ b;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/tlg_ctrl.sv =====
// Controller of the Tausworthe generator: accepts beats, sequences the
// datapath and owns the result valid. Depends on tlg_pkg and the macro header.
`default_nettype none
`include "tausworthe_lfsr_generator_macros.svh"

module tlg_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output tlg_pkg::cmd_t        cmd,
  input  wire tlg_pkg::status_t status
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  logic   out_free;

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd.load    = accept;
    cmd.advance = (state_r == ST_RUN) && !status.rem_zero;
    cmd.publish = (state_r == ST_RUN) && status.rem_zero && out_free;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (cmd.publish) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (cmd.publish) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `TLG_ASSERT_NEXT(a_accept_runs, clk, rst_n, accept, state_r == ST_RUN, "accepted beat did not start work")
  `TLG_ASSERT_NOW(a_no_overwrite, clk, rst_n, out_valid_r && out_stall, !cmd.publish, "pending result overwritten")
  `TLG_ASSERT_NEXT(a_publish_done, clk, rst_n, cmd.publish, state_r == ST_IDLE && out_valid_r, "publish did not present result")

endmodule

`default_nettype wire

// ===== hdl/tlg_dpath.sv =====
// Datapath of the Tausworthe generator: configuration registers, state word,
// bit-advance unit, quick-step logic and result register. Depends on tlg_pkg and the macro header.
`default_nettype none
`include "tausworthe_lfsr_generator_macros.svh"

module tlg_dpath (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_wr,
  input  wire logic [tlg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [tlg_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic                             in_command,
  input  wire logic [tlg_pkg::SEED_W-1:0]       in_seed_bits,
  input  wire tlg_pkg::cmd_t                    cmd,
  output tlg_pkg::status_t                      status,
  output logic [tlg_pkg::OUT_W-1:0]             state_word
);

  logic [tlg_pkg::K_W-1:0]  degree_r;
  logic [tlg_pkg::S_W-1:0]  step_r;
  logic [tlg_pkg::NT_W-1:0] ntaps_r;
  tlg_pkg::taps_t           taps_r;
  logic                     quick_r;

  tlg_pkg::word_t           work_r, work_nxt;
  logic [tlg_pkg::S_W-1:0]  rem_r, rem_nxt;
  tlg_pkg::word_t           out_word_r;

  logic [tlg_pkg::K_W-1:0]  k_eff;
  logic [tlg_pkg::P_W-1:0]  seed_shift;
  tlg_pkg::word_t           adv_word;

  // Hold the degree below the word width.
  always_comb begin
    if (int'(degree_r) >= tlg_pkg::WORD_BITS) begin
      k_eff = tlg_pkg::K_W'(tlg_pkg::WORD_BITS - 1);
    end else begin
      k_eff = degree_r;
    end
  end

  assign seed_shift = tlg_pkg::P_W'(tlg_pkg::WORD_BITS) - tlg_pkg::P_W'(k_eff);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      degree_r <= tlg_pkg::K_W'(31);
      step_r   <= tlg_pkg::S_W'(12);
      ntaps_r  <= tlg_pkg::NT_W'(1);
      taps_r   <= {tlg_pkg::TAP_W'(1), tlg_pkg::TAP_W'(1), tlg_pkg::TAP_W'(13)};
      quick_r  <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        tlg_pkg::REG_DEGREE_K:   degree_r  <= cfg_data[tlg_pkg::K_W-1:0];
        tlg_pkg::REG_STEP_S:     step_r    <= cfg_data[tlg_pkg::S_W-1:0];
        tlg_pkg::REG_MIDDLE_TAP: ntaps_r   <= cfg_data[tlg_pkg::NT_W-1:0];
        tlg_pkg::REG_TAP_ONE:    taps_r[0] <= cfg_data[tlg_pkg::TAP_W-1:0];
        tlg_pkg::REG_TAP_TWO:    taps_r[1] <= cfg_data[tlg_pkg::TAP_W-1:0];
        tlg_pkg::REG_TAP_THREE:  taps_r[2] <= cfg_data[tlg_pkg::TAP_W-1:0];
        tlg_pkg::REG_QUICK_MODE: quick_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Advance up to ADV_PER_CYCLE recurrence bits, one shift each.
  always_comb begin
    adv_word = work_r;
    for (int i = 0; i < tlg_pkg::ADV_PER_CYCLE; i++) begin
      if (i < int'(rem_r)) begin
        adv_word = tlg_pkg::advance_one(adv_word, k_eff, taps_r, ntaps_r);
      end
    end
  end

  always_comb begin
    work_nxt = work_r;
    rem_nxt  = rem_r;
    priority if (cmd.load) begin
      if (in_command == tlg_pkg::CMD_SEED) begin
        // Seed top bits start right-aligned and are pushed up while filling.
        work_nxt = in_seed_bits[tlg_pkg::WORD_BITS-1:0] >> seed_shift;
        rem_nxt  = tlg_pkg::S_W'(seed_shift);
      end else if (quick_r) begin
        work_nxt = tlg_pkg::quick_word(work_r, k_eff, step_r, taps_r, ntaps_r);
        rem_nxt  = '0;
      end else begin
        rem_nxt  = step_r;
      end
    end else if (cmd.advance) begin
      work_nxt = adv_word;
      rem_nxt  = (rem_r > tlg_pkg::S_W'(tlg_pkg::ADV_PER_CYCLE)) ?
                 (rem_r - tlg_pkg::S_W'(tlg_pkg::ADV_PER_CYCLE)) : '0;
    end else begin
      work_nxt = work_r;
      rem_nxt  = rem_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      work_r <= '0;
      rem_r  <= '0;
    end else begin
      work_r <= work_nxt;
      rem_r  <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) out_word_r <= work_r;
  end

  assign status.rem_zero = (rem_r == '0);
  assign state_word      = tlg_pkg::OUT_W'(out_word_r);

  `TLG_ASSERT_NEXT(a_rem_shrinks, clk, rst_n, cmd.advance, rem_r < $past(rem_r), "bit count did not drop")
  `TLG_ASSERT_NEXT(a_quick_one_pass, clk, rst_n, cmd.load && in_command == tlg_pkg::CMD_STEP && quick_r, rem_r == '0, "quick step left bits pending")
  `TLG_ASSERT_NEXT(a_publish_word, clk, rst_n, cmd.publish, state_word == tlg_pkg::OUT_W'($past(work_r)), "result differs from state")

endmodule

`default_nettype wire

// ===== hdl/tausworthe_lfsr_generator.sv =====
// Tausworthe generator over GF(2) with up to three configurable middle taps.
// A seed beat loads the top degree_k bits and fills the rest of the 32-bit
// state; a step beat advances the recurrence by step_s bits, or in quick mode
// applies the word-parallel formula. Each beat returns the new state word.
// The bit-advance unit shifts in four recurrence bits per cycle. A seed needs
// 32 - degree_k such bits, a general step step_s bits and a quick step none.
// A beat is accepted only once the previous one is published, and the next
// beat is accepted while the previous result still waits.
// Configuration writes are always ready and must only be issued while idle.
`default_nettype none

module tausworthe_lfsr_generator (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic                            in_command,
  input  wire logic [tlg_pkg::SEED_W-1:0]      in_seed_bits,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [tlg_pkg::OUT_W-1:0]            out_state_word,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [tlg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [tlg_pkg::CFG_DATA_W-1:0]  cfg_data
);

  tlg_pkg::cmd_t    cmd;
  tlg_pkg::status_t status;
  logic             cfg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  tlg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  tlg_dpath u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr       (cfg_wr),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_command   (in_command),
    .in_seed_bits (in_seed_bits),
    .cmd          (cmd),
    .status       (status),
    .state_word   (out_state_word)
  );

endmodule

`default_nettype wire
